// ===== hdl/pfd_pkg.sv =====
// Shared package for the PPM frame decoder: constants, configuration and
// item types, and the state encodings of the front and back parts.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package pfd_pkg;

    // Frame limits in channels.
    localparam int MIN_CHANNELS = 4;
    localparam int MAX_CHANNELS = 16;
    localparam int STORE_DEPTH  = 16;

    // Field widths.
    localparam int TIME_W    = 16;
    localparam int PULSE_W   = 13;
    localparam int VAL_W     = 11;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_CHANNELS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);

    // Interval classification limits in timer ticks.
    localparam logic [TIME_W-1:0]  SHORT_LIMIT  = 16'd1600;
    localparam logic [TIME_W-1:0]  SYNC_LIMIT   = 16'd4400;
    localparam logic [PULSE_W-1:0] CENTRE_PULSE = 13'd3000;

    // Queue depths; both must be powers of two so the pointers wrap on their own.
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Divider: magnitude of the scaled product fits in 24 bits.
    localparam int QUO_W  = 24;
    localparam int PROD_W = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_IN_MIN  = 3'd0,
        CFG_PULSE_IN_MAX  = 3'd1,
        CFG_CHAN_OUT_MIN  = 3'd2,
        CFG_CHAN_OUT_MAX  = 3'd3,
        CFG_CLAMP_LOW     = 3'd4,
        CFG_CLAMP_HIGH    = 3'd5,
        CFG_CHANNEL_ORDER = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_in_min;
        logic [PULSE_W-1:0] pulse_in_max;
        logic [VAL_W-1:0]   chan_out_min;
        logic [VAL_W-1:0]   chan_out_max;
        logic [VAL_W-1:0]   clamp_low;
        logic [VAL_W-1:0]   clamp_high;
        logic [31:0]        channel_order;
    } t_cfg;

    // One channel conversion handed from the front to the back.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_result;

    typedef enum logic {
        F_ACCEPT,
        F_SWEEP
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_PREP,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage

// ===== hdl/pfd_front.sv =====
// Front part of the PPM frame decoder: measures edge intervals, keeps the
// pulse store and frame state, and sweeps a finished frame into the job queue.
// Depends on pfd_pkg.
module pfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [pfd_pkg::TIME_W-1:0]    i_edge_time,
    input  logic [31:0]                   i_channel_order,
    output logic                          o_job_push,
    input  logic                          i_job_full,
    output pfd_pkg::t_job                 o_job
);

    pfd_pkg::t_front_state r_state, n_state;

    logic [pfd_pkg::TIME_W-1:0]  r_prev_edge;
    logic [pfd_pkg::CNT_W-1:0]   r_count;
    logic                        r_bad;
    logic [pfd_pkg::PULSE_W-1:0] r_store [pfd_pkg::STORE_DEPTH];
    logic [pfd_pkg::STORE_DEPTH-1:0] r_store_vld;
    logic [pfd_pkg::CNT_W-1:0]   r_max_seen;
    logic [pfd_pkg::CNT_W-1:0]   r_sweep;

    logic                        accept;
    logic [pfd_pkg::TIME_W-1:0]  interval;
    logic                        is_short;
    logic                        is_sync;
    logic                        frame_ok;
    logic                        store_wr;
    logic [pfd_pkg::CNT_W-1:0]   max_new;
    logic                        sweep_last;
    logic [pfd_pkg::IDX_W-1:0]   nib;
    logic [4:0]                  nib_sel;

    assign accept   = i_push && !o_full;
    assign interval = i_edge_time - r_prev_edge;
    assign is_short = interval < pfd_pkg::SHORT_LIMIT;
    assign is_sync  = interval > pfd_pkg::SYNC_LIMIT;
    assign frame_ok = r_count >= pfd_pkg::MIN_CNT;
    assign store_wr = accept && !is_short && !is_sync && !r_bad &&
                      (r_count < pfd_pkg::MAX_CNT);
    assign max_new  = (r_count > r_max_seen) ? r_count : r_max_seen;
    assign sweep_last = (r_sweep == (r_max_seen - 5'd1));

    // Nibble i counted from the top of the order word.
    assign nib_sel = {3'd7 - r_sweep[2:0], 2'b00};
    assign nib     = i_channel_order[nib_sel +: 4];

    always_comb begin
        o_job.idx   = r_sweep[pfd_pkg::IDX_W-1:0];
        if ((r_sweep < 5'd8) && (nib != 4'd0)) begin
            o_job.idx = nib - 4'd1;
        end
        o_job.pulse = r_store_vld[r_sweep[3:0]] ? r_store[r_sweep[3:0]]
                                                 : pfd_pkg::CENTRE_PULSE;
        o_job.last  = sweep_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfd_pkg::F_ACCEPT: begin
                if (accept && is_sync && frame_ok) begin
                    n_state = pfd_pkg::F_SWEEP;
                end
            end
            pfd_pkg::F_SWEEP: begin
                if (!i_job_full && sweep_last) begin
                    n_state = pfd_pkg::F_ACCEPT;
                end
            end
            default: n_state = pfd_pkg::F_ACCEPT;
        endcase
    end

    always_comb begin
        o_full     = 1'b1;
        o_job_push = 1'b0;
        case (r_state)
            pfd_pkg::F_ACCEPT: o_full = 1'b0;
            pfd_pkg::F_SWEEP:  o_job_push = !i_job_full;
            default:           o_full = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfd_pkg::F_ACCEPT;
            r_prev_edge <= '0;
            r_count     <= '0;
            r_bad       <= 1'b1;
            r_store_vld <= '0;
            r_max_seen  <= '0;
            r_sweep     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_prev_edge <= i_edge_time;
                if (is_short) begin
                    r_bad <= 1'b1;
                end else if (is_sync) begin
                    if (frame_ok) begin
                        r_max_seen <= max_new;
                        r_sweep    <= '0;
                    end
                    r_count <= '0;
                    r_bad   <= 1'b0;
                end else if (!r_bad) begin
                    if (r_count < pfd_pkg::MAX_CNT) begin
                        r_store_vld[r_count[3:0]] <= 1'b1;
                        r_count <= r_count + 5'd1;
                    end else begin
                        r_bad <= 1'b1;
                    end
                end
            end
            if (o_job_push) begin
                r_sweep <= r_sweep + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[r_count[3:0]] <= interval[pfd_pkg::PULSE_W-1:0];
        end
    end

endmodule

// ===== hdl/pfd_job_queue.sv =====
// Short queue of channel conversions between the front and back parts.
// Depends on pfd_pkg for the job type and depth.
module pfd_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  pfd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output pfd_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(pfd_pkg::JOB_DEPTH);
    localparam int CNT_W = $clog2(pfd_pkg::JOB_DEPTH + 1);

    pfd_pkg::t_job    r_mem [pfd_pkg::JOB_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(pfd_pkg::JOB_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== hdl/pfd_back.sv =====
// Back part of the PPM frame decoder: rescales each channel with a multiply
// and a bit-serial divide, clamps it, and queues the result for the output.
// Depends on pfd_pkg.
module pfd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfd_pkg::t_cfg               i_cfg,
    input  logic                        i_job_empty,
    output logic                        o_job_pop,
    input  pfd_pkg::t_job               i_job,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [pfd_pkg::IDX_W-1:0]   o_channel_index,
    output logic [pfd_pkg::VAL_W-1:0]   o_channel_value,
    output logic                        o_last_of_frame
);

    localparam int OPTR_W = $clog2(pfd_pkg::OUT_DEPTH);
    localparam int OCNT_W = $clog2(pfd_pkg::OUT_DEPTH + 1);
    localparam int BIT_W  = $clog2(pfd_pkg::QUO_W);

    pfd_pkg::t_back_state r_state, n_state;

    logic [pfd_pkg::IDX_W-1:0]          r_idx;
    logic                               r_last;
    logic signed [pfd_pkg::PULSE_W:0]   r_d;
    logic signed [pfd_pkg::PROD_W-1:0]  r_prod;
    logic [pfd_pkg::QUO_W-1:0]          r_quo;
    logic [pfd_pkg::PULSE_W-1:0]        r_rem;
    logic [pfd_pkg::PULSE_W-1:0]        r_div;
    logic                               r_neg;
    logic [BIT_W-1:0]                   r_bit;

    pfd_pkg::t_result  r_out [pfd_pkg::OUT_DEPTH];
    logic [OPTR_W-1:0] r_wptr;
    logic [OPTR_W-1:0] r_rptr;
    logic [OCNT_W-1:0] r_ocnt;

    logic signed [pfd_pkg::VAL_W:0]    span_out;
    logic signed [pfd_pkg::PULSE_W:0]  span_in;
    logic [pfd_pkg::PULSE_W:0]         span_in_abs;
    logic [pfd_pkg::PROD_W-1:0]        prod_abs;
    logic [pfd_pkg::PULSE_W:0]         trial;
    logic [pfd_pkg::PULSE_W:0]         trial_diff;
    logic                              trial_ge;
    logic signed [pfd_pkg::PROD_W-1:0] quo_s;
    logic signed [pfd_pkg::PROD_W-1:0] scaled;
    logic [pfd_pkg::VAL_W-1:0]         clamped;
    logic                              out_wr;
    logic                              out_rd;
    logic                              div_done;
    pfd_pkg::t_result                  res;

    assign span_out = $signed({1'b0, i_cfg.chan_out_max}) -
                      $signed({1'b0, i_cfg.chan_out_min});
    assign span_in  = $signed({1'b0, i_cfg.pulse_in_max}) -
                      $signed({1'b0, i_cfg.pulse_in_min});
    assign span_in_abs = span_in[pfd_pkg::PULSE_W] ? 14'(-span_in) : span_in;
    assign prod_abs    = r_prod[pfd_pkg::PROD_W-1] ? 26'(-r_prod) : r_prod;

    // One restoring divide step per cycle.
    assign trial      = {r_rem, r_quo[pfd_pkg::QUO_W-1]};
    assign trial_ge   = trial >= {1'b0, r_div};
    assign trial_diff = trial - {1'b0, r_div};
    assign div_done   = (r_bit == BIT_W'(pfd_pkg::QUO_W - 1));

    // Quotient truncates toward zero: divide magnitudes, then apply the sign.
    always_comb begin
        quo_s  = $signed({2'b00, r_quo});
        if (r_neg) begin
            quo_s = -$signed({2'b00, r_quo});
        end
        scaled = quo_s + $signed({15'd0, i_cfg.chan_out_min});
        if (scaled < 0) begin
            clamped = i_cfg.clamp_low;
        end else if (scaled > $signed({15'd0, i_cfg.clamp_high})) begin
            clamped = i_cfg.clamp_high;
        end else begin
            clamped = scaled[pfd_pkg::VAL_W-1:0];
        end
        res.idx   = r_idx;
        res.value = clamped;
        res.last  = r_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfd_pkg::B_IDLE: begin
                if (!i_job_empty) begin
                    n_state = pfd_pkg::B_MUL;
                end
            end
            pfd_pkg::B_MUL:  n_state = pfd_pkg::B_PREP;
            pfd_pkg::B_PREP: begin
                if (span_in == 0) begin
                    n_state = pfd_pkg::B_DONE;
                end else begin
                    n_state = pfd_pkg::B_DIV;
                end
            end
            pfd_pkg::B_DIV: begin
                if (div_done) begin
                    n_state = pfd_pkg::B_DONE;
                end
            end
            pfd_pkg::B_DONE: begin
                if (r_ocnt != OCNT_W'(pfd_pkg::OUT_DEPTH)) begin
                    n_state = pfd_pkg::B_IDLE;
                end
            end
            default: n_state = pfd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = 1'b0;
        out_wr    = 1'b0;
        case (r_state)
            pfd_pkg::B_IDLE: o_job_pop = !i_job_empty;
            pfd_pkg::B_DONE: out_wr = (r_ocnt != OCNT_W'(pfd_pkg::OUT_DEPTH));
            default: begin
                o_job_pop = 1'b0;
                out_wr    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            pfd_pkg::B_IDLE: begin
                r_idx  <= i_job.idx;
                r_last <= i_job.last;
                r_d    <= $signed({1'b0, i_job.pulse}) - $signed({1'b0, i_cfg.pulse_in_min});
            end
            pfd_pkg::B_MUL: begin
                r_prod <= span_out * r_d;
            end
            pfd_pkg::B_PREP: begin
                r_div <= span_in_abs[pfd_pkg::PULSE_W-1:0];
                r_rem <= '0;
                r_bit <= '0;
                r_neg <= r_prod[pfd_pkg::PROD_W-1] ^ span_in[pfd_pkg::PULSE_W];
                if (span_in == 0) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= prod_abs[pfd_pkg::QUO_W-1:0];
                end
            end
            pfd_pkg::B_DIV: begin
                r_rem <= trial_ge ? trial_diff[pfd_pkg::PULSE_W-1:0]
                                  : trial[pfd_pkg::PULSE_W-1:0];
                r_quo <= {r_quo[pfd_pkg::QUO_W-2:0], trial_ge};
                r_bit <= r_bit + 1'b1;
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

    // Output queue.
    assign o_empty         = (r_ocnt == '0);
    assign out_rd          = i_pop && !o_empty;
    assign o_channel_index = r_out[r_rptr].idx;
    assign o_channel_value = r_out[r_rptr].value;
    assign o_last_of_frame = r_out[r_rptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_ocnt <= '0;
        end else begin
            if (out_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (out_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({out_wr, out_rd})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out[r_wptr] <= res;
        end
    end

endmodule

// ===== hdl/ppm_frame_decoder_top.sv =====
// PPM frame decoder top level. For each channel the back captures the job, multiplies,
// sets up the divide, runs 24 divide steps and writes the result; with equal input limits
// it skips the divide steps. A sync edge that closes a frame holds full high while the
// front sweeps the pulse store into the two-entry job queue; the sweep lasts longer
// while pops stall. Synchronous active-low reset restores register defaults.
module ppm_frame_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Edge input queue.
    input  logic                           push,
    output logic                           full,
    input  logic [pfd_pkg::TIME_W-1:0]     i_edge_time,
    // Result queue.
    output logic                           empty,
    input  logic                           pop,
    output logic [pfd_pkg::IDX_W-1:0]      o_channel_index,
    output logic [pfd_pkg::VAL_W-1:0]      o_channel_value,
    output logic                           o_last_of_frame,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfd_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    // The configuration registers are always ready. Writes to indexes past
    // the channel order register are accepted and ignored.
    pfd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_in_min  <= 13'd2200;
            r_cfg.pulse_in_max  <= 13'd3800;
            r_cfg.chan_out_min  <= 11'd204;
            r_cfg.chan_out_max  <= 11'd1844;
            r_cfg.clamp_low     <= 11'd0;
            r_cfg.clamp_high    <= 11'd2047;
            r_cfg.channel_order <= 32'd0;
        end else if (i_cfg_valid) begin
            case (pfd_pkg::t_cfg_index'(i_cfg_index))
                pfd_pkg::CFG_PULSE_IN_MIN:
                    r_cfg.pulse_in_min <= i_cfg_data[pfd_pkg::PULSE_W-1:0];
                pfd_pkg::CFG_PULSE_IN_MAX:
                    r_cfg.pulse_in_max <= i_cfg_data[pfd_pkg::PULSE_W-1:0];
                pfd_pkg::CFG_CHAN_OUT_MIN:
                    r_cfg.chan_out_min <= i_cfg_data[pfd_pkg::VAL_W-1:0];
                pfd_pkg::CFG_CHAN_OUT_MAX:
                    r_cfg.chan_out_max <= i_cfg_data[pfd_pkg::VAL_W-1:0];
                pfd_pkg::CFG_CLAMP_LOW:
                    r_cfg.clamp_low <= i_cfg_data[pfd_pkg::VAL_W-1:0];
                pfd_pkg::CFG_CLAMP_HIGH:
                    r_cfg.clamp_high <= i_cfg_data[pfd_pkg::VAL_W-1:0];
                pfd_pkg::CFG_CHANNEL_ORDER:
                    r_cfg.channel_order <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // The front classifies edges and, at a sync gap closing a long enough frame, emits one job
    // per channel of the widest frame seen; the job queue lets the sweep run ahead of the back.
    logic          front_push;
    logic          queue_full;
    logic          queue_empty;
    logic          back_pop;
    pfd_pkg::t_job front_job;
    pfd_pkg::t_job back_job;

    pfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_edge_time     (i_edge_time),
        .i_channel_order (r_cfg.channel_order),
        .o_job_push      (front_push),
        .i_job_full      (queue_full),
        .o_job           (front_job)
    );

    pfd_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_full  (queue_full),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_empty (queue_empty),
        .o_job   (back_job)
    );

    // The back rescales each channel and holds finished items in its
    // output queue until the consumer pops them.
    pfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_empty     (queue_empty),
        .o_job_pop       (back_pop),
        .i_job           (back_job),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== hdl/pfd_checker.sv =====
// Port-level checks for the PPM frame decoder top level, bound to it below.
// Depends on pfd_pkg for the port widths.
module pfd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [pfd_pkg::IDX_W-1:0]    o_channel_index,
    input logic [pfd_pkg::VAL_W-1:0]    o_channel_value,
    input logic                         o_last_of_frame
);

    // Reset leaves no results.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty ##1 empty)
        else $error("result visible too soon after reset");

    // Reset leaves the front ready for an edge.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input full right after reset");

    // A waiting result holds until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_channel_index) &&
                              $stable(o_channel_value) && $stable(o_last_of_frame)))
        else $error("waiting result changed before pop");

endmodule

bind ppm_frame_decoder_top pfd_checker u_pfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_last_of_frame (o_last_of_frame)
);

// ===== test/tb_ppm_frame_decoder_top.sv =====
// Self-checking testbench for ppm_frame_decoder_top: PPM edge items go in,
// channel items come out, and a behavioral decoder predicts every channel item.
// Depends on pfd_pkg (hdl/pfd_pkg.sv) and the decoder RTL.
module tb_ppm_frame_decoder_top;

    import pfd_pkg::*;

    // The settle time after the last expected channel item is longer than the
    // time the back takes to finish a full 16-channel frame after its sync edge.
    localparam int SETTLE_CYCLES = 600;
    // Long receiver hold-off used to back the decoder up to its input.
    localparam int HOLD_CYCLES   = 3000;
    // Watchdog limit, well above the slowest legal run.
    localparam int CYCLE_LIMIT   = 1000000;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [TIME_W-1:0]      i_edge_time = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [IDX_W-1:0]       o_channel_index;
    logic [VAL_W-1:0]       o_channel_value;
    logic                   o_last_of_frame;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ppm_frame_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_edge_time     (i_edge_time),
        .empty           (empty),
        .pop             (pop),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Stimulus bookkeeping.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] edge_backlog[$];    // edge times waiting for the driver
    logic [TIME_W-1:0] stim_clock = '0;    // timer value of the last queued edge
    int unsigned       edges_queued = 0;
    int unsigned       edges_taken  = 0;
    logic              edge_fire    = 1'b0; // an edge item was accepted at the last rising edge

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    logic              hold_req = 1'b0;
    logic              rx_hold  = 1'b0;

    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;

    // ------------------------------------------------------------------
    // Behavioral decoder. It keeps its own copy of the registers and of
    // the frame state, and turns every accepted edge into the channel
    // items that edge should produce.
    // ------------------------------------------------------------------
    t_cfg              regs;
    logic [TIME_W-1:0] last_edge    = '0;
    logic [CNT_W-1:0]  stored_cnt   = '0;
    logic              frame_broken = 1'b1;   // wait for the first sync gap
    logic [PULSE_W-1:0] pulse_mem[STORE_DEPTH];
    logic [CNT_W-1:0]  widest_frame = '0;     // most channels ever seen in a good close
    t_result           chan_expect[$];        // channel items still to come out

    initial begin
        regs.pulse_in_min  = 13'd2200;
        regs.pulse_in_max  = 13'd3800;
        regs.chan_out_min  = 11'd204;
        regs.chan_out_max  = 11'd1844;
        regs.clamp_low     = 11'd0;
        regs.clamp_high    = 11'd2047;
        regs.channel_order = 32'd0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            pulse_mem[i] = CENTRE_PULSE;
        end
    end

    // Linear rescale with truncating division. A negative result takes the
    // low clamp value; anything above the high clamp saturates there.
    function automatic logic [VAL_W-1:0] scale_width(input logic [PULSE_W-1:0] pulse);
        longint d, span_out, span_in, q, v;
        d        = longint'(pulse) - longint'(regs.pulse_in_min);
        span_out = longint'(regs.chan_out_max) - longint'(regs.chan_out_min);
        span_in  = longint'(regs.pulse_in_max) - longint'(regs.pulse_in_min);
        // Equal input limits leave the quotient at zero.
        q = (span_in != 0) ? (span_out * d) / span_in : 0;
        v = q + longint'(regs.chan_out_min);
        if (v < 0) begin
            return regs.clamp_low;
        end
        if (v > longint'(regs.clamp_high)) begin
            v = longint'(regs.clamp_high);
        end
        return v[VAL_W-1:0];
    endfunction

    // Only the first eight channels can be moved; a zero nibble keeps the
    // channel where it is, and several channels may land on one index.
    function automatic logic [IDX_W-1:0] dest_slot(input int unsigned ch);
        logic [3:0] nib;
        nib = 4'd0;
        if (ch < 8) begin
            nib = regs.channel_order[31 - 4*ch -: 4];
        end
        return (nib != 4'd0) ? nib - 4'd1 : ch[IDX_W-1:0];
    endfunction

    function automatic void track_edge(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] gap;
        t_result           r;
        gap = t - last_edge;
        last_edge = t;
        if (gap < SHORT_LIMIT) begin
            frame_broken = 1'b1;
        end else if (gap > SYNC_LIMIT) begin
            // Sync gap: a frame with enough channels is emitted at the
            // largest width seen so far, stale store entries included.
            if (stored_cnt >= MIN_CNT) begin
                if (stored_cnt > widest_frame) begin
                    widest_frame = stored_cnt;
                end
                for (int i = 0; i < widest_frame && i < STORE_DEPTH; i++) begin
                    r.idx   = dest_slot(i);
                    r.value = scale_width(pulse_mem[i]);
                    r.last  = (i == widest_frame - 1);
                    chan_expect.push_back(r);
                end
            end
            stored_cnt   = '0;
            frame_broken = 1'b0;
        end else if (!frame_broken) begin
            // One channel too many spoils the frame but keeps the count.
            if (stored_cnt < MAX_CNT) begin
                pulse_mem[stored_cnt] = gap[PULSE_W-1:0];
                stored_cnt = stored_cnt + 1'b1;
            end else begin
                frame_broken = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Edge driver: offers the next queued edge at the falling clock edge,
    // holding the current one until the decoder has taken it.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : edge_driver
        if (!push || edge_fire) begin
            if (i_rst_n && edge_backlog.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                i_edge_time <= edge_backlog.pop_front();
                push        <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Channel receiver: pops at random, and not at all during a hold-off.
    always @(negedge i_clk) begin : chan_receiver
        pop <= i_rst_n && !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // The long hold-off runs in its own process once requested.
    initial begin : rx_hold_off
        wait (hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising clock edge. Channel
    // items are checked against the oldest expectation before the edge
    // taken in the same cycle is run through the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && pop && empty == 1'b0) begin
            if (chan_expect.size() == 0) begin
                flag_mismatch($sformatf("unexpected channel item idx %0d value %0d last %0d",
                                        o_channel_index, o_channel_value, o_last_of_frame));
            end else begin
                want = chan_expect.pop_front();
                if (o_channel_index !== want.idx) begin
                    flag_mismatch($sformatf("channel_index %0d, expected %0d",
                                            o_channel_index, want.idx));
                end
                if (o_channel_value !== want.value) begin
                    flag_mismatch($sformatf("channel_value %0d, expected %0d",
                                            o_channel_value, want.value));
                end
                if (o_last_of_frame !== want.last) begin
                    flag_mismatch($sformatf("last_of_frame %0d, expected %0d",
                                            o_last_of_frame, want.last));
                end
            end
        end
        if (i_rst_n && push && full == 1'b0) begin
            track_edge(i_edge_time);
            edges_taken++;
            edge_fire <= 1'b1;
        end else begin
            edge_fire <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ppm_frame_decoder_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Queues an edge a given number of ticks after the previous one; the
    // timer wraps at 16 bits just like the real capture register.
    task automatic queue_gap(input int unsigned gap);
        stim_clock = stim_clock + 16'(gap);
        edge_backlog.push_back(stim_clock);
        edges_queued++;
    endtask

    // Register writes happen only with the decoder idle; the predictor's
    // copy is updated at the handshake.
    task automatic write_reg(input t_cfg_index which, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (which)
            CFG_PULSE_IN_MIN:  regs.pulse_in_min  = data[PULSE_W-1:0];
            CFG_PULSE_IN_MAX:  regs.pulse_in_max  = data[PULSE_W-1:0];
            CFG_CHAN_OUT_MIN:  regs.chan_out_min  = data[VAL_W-1:0];
            CFG_CHAN_OUT_MAX:  regs.chan_out_max  = data[VAL_W-1:0];
            CFG_CLAMP_LOW:     regs.clamp_low     = data[VAL_W-1:0];
            CFG_CLAMP_HIGH:    regs.clamp_high    = data[VAL_W-1:0];
            CFG_CHANNEL_ORDER: regs.channel_order = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned pin_min, input int unsigned pin_max,
                                 input int unsigned out_min, input int unsigned out_max,
                                 input int unsigned lo, input int unsigned hi,
                                 input logic [31:0] order);
        write_reg(CFG_PULSE_IN_MIN, pin_min);
        write_reg(CFG_PULSE_IN_MAX, pin_max);
        write_reg(CFG_CHAN_OUT_MIN, out_min);
        write_reg(CFG_CHAN_OUT_MAX, out_max);
        write_reg(CFG_CLAMP_LOW, lo);
        write_reg(CFG_CLAMP_HIGH, hi);
        write_reg(CFG_CHANNEL_ORDER, order);
    endtask

    // Mostly well-formed frames (sync gap, then a channel run of random
    // length and content), with some corrupted channels and raw noise.
    // A closing sync at the end makes the last frame come out.
    task automatic build_frames(input int unsigned count);
        int unsigned made, chans, pick;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    queue_gap(SYNC_LIMIT + 1);
                end else if (pick < 15) begin
                    queue_gap(65535);
                end else begin
                    queue_gap($urandom_range(65535, SYNC_LIMIT + 1));
                end
                made++;
                pick = $urandom_range(99);
                if (pick < 60) begin
                    chans = $urandom_range(8, MIN_CHANNELS);
                end else if (pick < 80) begin
                    chans = $urandom_range(MAX_CHANNELS, 9);
                end else if (pick < 90) begin
                    chans = $urandom_range(MAX_CHANNELS + 2, MAX_CHANNELS + 1);
                end else begin
                    chans = $urandom_range(MIN_CHANNELS - 1, 0);
                end
                for (int k = 0; k < chans; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 4) begin
                        queue_gap($urandom_range(SHORT_LIMIT - 1, 0));
                    end else if (pick < 12) begin
                        queue_gap(SHORT_LIMIT);
                    end else if (pick < 20) begin
                        queue_gap(SYNC_LIMIT);
                    end else begin
                        queue_gap($urandom_range(SYNC_LIMIT, SHORT_LIMIT));
                    end
                    made++;
                end
            end else if (pick < 90) begin
                queue_gap($urandom_range(65535, 0));
                made++;
            end else begin
                queue_gap($urandom_range(SHORT_LIMIT - 1, 0));
                made++;
            end
        end
        queue_gap(SYNC_LIMIT + 1);
    endtask

    // Waits until every queued edge is taken and every predicted channel
    // item has come out, then lets a full frame's worth of cycles pass.
    task automatic settle;
        while (edges_taken != edges_queued) @(posedge i_clk);
        while (chan_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : sequencer
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Sender idles now and then, receiver mostly idles.
        @(posedge i_clk);
        send_idle_pct = 19;
        recv_idle_pct = 76;

        // Directed part with the reset register values. The first sync
        // opens a frame of seventeen channels: the boundary widths (the
        // shortest scales negative and clamps low, the longest saturates
        // high), and one channel too many, which spoils the frame but still
        // closes with sixteen channels out.
        queue_gap(5000);
        queue_gap(SHORT_LIMIT);
        queue_gap(SYNC_LIMIT);
        queue_gap(2200);
        queue_gap(3800);
        queue_gap(3000);
        for (int k = 0; k < 12; k++) begin
            queue_gap(1800 + 200 * k);
        end
        queue_gap(SYNC_LIMIT + 1);
        // Just too short, then the longest possible gap as a sync.
        queue_gap(SHORT_LIMIT - 1);
        queue_gap(65535);
        // A frame too short to emit.
        queue_gap(2000);
        queue_gap(2500);
        queue_gap(20000);
        // An edge at the same timer value as the one before it, then a resync.
        queue_gap(0);
        queue_gap(SYNC_LIMIT + 1);
        settle();

        // Swapped channel pairs in the first eight slots.
        apply_setting(2200, 3800, 204, 1844, 0, 2047, 32'h2143_6587);
        build_frames(70);
        settle();

        // Full input span and full output range with both clamp values at the top;
        // every remapped channel collides on index 14.
        apply_setting(0, 8191, 0, 2047, 2047, 2047, 32'hFFFF_FFFF);
        build_frames(70);
        settle();

        // Sender mostly idles, receiver quick.
        send_idle_pct = 76;
        recv_idle_pct = 19;

        // Equal input limits: every channel takes the output minimum, which here saturates at the high clamp.
        apply_setting(3000, 3000, 1000, 0, 5, 500, 32'h1111_1111);
        build_frames(70);
        settle();

        // One-tick input span: huge slopes saturate high, short widths
        // go negative and take the low clamp.
        apply_setting(4000, 4001, 0, 2047, 123, 1500, 32'h9ABC_DEF0);
        build_frames(70);
        settle();

        // No idling from here on. The receiver holds off for a long
        // stretch first while edges keep coming, so the decoder backs up
        // and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(8191, 0, 2047, 0, 777, 1000, 32'h0102_0304);
        @(posedge i_clk);
        hold_req = 1'b1;
        build_frames(70);
        settle();

        // All registers at zero.
        apply_setting(0, 0, 0, 0, 0, 0, 32'h0000_0000);
        build_frames(70);
        settle();

        // Random register values.
        apply_setting($urandom_range(8191, 0), $urandom_range(8191, 0),
                      $urandom_range(2047, 0), $urandom_range(2047, 0),
                      $urandom_range(2047, 0), $urandom_range(2047, 0), $urandom);
        build_frames(70);
        settle();

        if (chan_expect.size() != 0) begin
            flag_mismatch($sformatf("%0d channel items never came out", chan_expect.size()));
        end
        if (mismatches == 0) begin
            $display("ppm_frame_decoder_top test passed");
        end else begin
            $display("ppm_frame_decoder_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pfd_pkg.sv
hdl/pfd_front.sv
hdl/pfd_job_queue.sv
hdl/pfd_back.sv
hdl/ppm_frame_decoder_top.sv
hdl/pfd_checker.sv
test/tb_ppm_frame_decoder_top.sv
